// File: src/clock_digit_glow_pixel_macros.svh
// Assertion helpers for the checker file.
`ifndef CLOCK_DIGIT_GLOW_PIXEL_MACROS_SVH
`define CLOCK_DIGIT_GLOW_PIXEL_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define CDGP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define CDGP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cdgp_pkg.sv
package cdgp_pkg;

  localparam int ROW_W      = 6;
  localparam int COL_W      = 7;
  localparam int CODE_W     = 4;
  localparam int NUM_CHARS  = 8;
  localparam int HUE_W      = 9;
  localparam int LEVEL_W    = 16;
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 128;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W     = $clog2(STORE_DEPTH);
  localparam int GLYPH_ROWS = 10;
  localparam int ROW_MARGIN = 4;
  localparam int START_W    = 6;

  localparam logic [CODE_W-1:0] COLON_CODE = 4'd10;
  localparam logic [CODE_W-1:0] DIGIT_ONE  = 4'd1;
  localparam logic [CODE_W-1:0] DIGIT_MAX  = 4'd9;

  // One byte per glyph row, bit c is column offset c. Entry ten is the colon.
  localparam logic [7:0] GLYPH [0:10][0:GLYPH_ROWS-1] = '{
    '{8'h3C, 8'h7E, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h7E, 8'h3C},
    '{8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06},
    '{8'h3E, 8'h7E, 8'h60, 8'h60, 8'h7C, 8'h3E, 8'h06, 8'h06, 8'h7E, 8'h7E},
    '{8'h3E, 8'h7E, 8'h60, 8'h60, 8'h38, 8'h38, 8'h60, 8'h60, 8'h7E, 8'h3E},
    '{8'h66, 8'h66, 8'h66, 8'h66, 8'h7E, 8'h7C, 8'h60, 8'h60, 8'h60, 8'h60},
    '{8'h7E, 8'h7E, 8'h06, 8'h06, 8'h3E, 8'h7E, 8'h60, 8'h60, 8'h7E, 8'h3E},
    '{8'h7C, 8'h7E, 8'h06, 8'h06, 8'h3E, 8'h7E, 8'h66, 8'h66, 8'h7E, 8'h3C},
    '{8'h7E, 8'h7E, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60},
    '{8'h3C, 8'h7E, 8'h66, 8'h66, 8'h3C, 8'h3C, 8'h66, 8'h66, 8'h7E, 8'h3C},
    '{8'h3C, 8'h7E, 8'h66, 8'h66, 8'h7E, 8'h7C, 8'h60, 8'h60, 8'h60, 8'h60},
    '{8'h00, 8'h00, 8'h06, 8'h06, 8'h00, 8'h00, 8'h06, 8'h06, 8'h00, 8'h00}
  };

  typedef logic [NUM_CHARS-1:0][CODE_W-1:0] codes_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    codes_t           code;
  } s1_t;

  typedef struct packed {
    logic [ROW_W-1:0]                   row;
    logic [COL_W-1:0]                   col;
    logic [HUE_W-1:0]                   hue;
    logic [8:0]                         cc;     // signed column relative to string origin
    logic [7:0]                         rr;     // signed row relative to glyph origin
    codes_t                             code;
    logic [NUM_CHARS-1:0][START_W-1:0]  start;
  } s2_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [HUE_W-1:0] hue;
    logic             lit;
  } s3_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [HUE_W-1:0]   hue;
    logic [LEVEL_W-1:0] level;
    logic               lit;
  } res_t;

  typedef struct packed {
    logic adv;
    logic s4_vld;
  } ctl_t;

  function automatic logic [3:0] char_width(logic [CODE_W-1:0] code);
    logic [3:0] w;
    if (code == COLON_CODE || code == DIGIT_ONE) begin
      w = 4'd4;
    end else if (code <= DIGIT_MAX) begin
      w = 4'd8;
    end else begin
      w = 4'd0;
    end
    return w;
  endfunction

  function automatic logic glyph_bit(logic [CODE_W-1:0] code, logic [3:0] r, logic [2:0] c);
    logic [7:0] bits;
    bits = 8'h00;
    if (code <= COLON_CODE && r < 4'(GLYPH_ROWS)) begin
      bits = GLYPH[code][r];
    end
    return bits[c];
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(logic [ROW_W-1:0] row,
                                                   logic [COL_W-1:0] col);
    // MAX_COLS is a power of two, so row*MAX_COLS+col is a concatenation.
    return {row, col};
  endfunction

endpackage

// File: src/cdgp_layout.sv
module cdgp_layout (
  input  logic             clk,
  input  logic             adv,
  input  cdgp_pkg::s1_t    s1,
  input  logic [6:0]       active_rows,
  input  logic [7:0]       active_cols,
  output cdgp_pkg::s2_t    s2_r
);

  cdgp_pkg::s2_t s2_nxt;

  always_comb begin
    logic [6:0]        acc;
    logic [3:0]        w;
    logic signed [9:0] diff;
    logic signed [9:0] x0;
    logic signed [9:0] cc;
    logic signed [9:0] rr;
    logic [7:0]        sum;
    logic [9:0]        h3;
    acc = '0;
    s2_nxt = '0;
    for (int k = 0; k < cdgp_pkg::NUM_CHARS; k++) begin
      w = cdgp_pkg::char_width(s1.code[k]);
      s2_nxt.start[k] = acc[cdgp_pkg::START_W-1:0];
      acc = acc + {3'b000, w};
    end
    // Floor of half the free width, which may be negative.
    diff = $signed({2'b00, active_cols}) - $signed({3'b000, acc});
    x0   = diff >>> 1;
    cc   = $signed({3'b000, s1.col}) - x0;
    rr   = $signed({4'b0000, s1.row}) - ($signed({3'b000, active_rows})
           - 10'(cdgp_pkg::ROW_MARGIN + cdgp_pkg::GLYPH_ROWS));
    sum  = {2'b00, s1.row} + {1'b0, s1.col};
    h3   = {1'b0, sum, 1'b0} + {2'b00, sum};
    s2_nxt.row  = s1.row;
    s2_nxt.col  = s1.col;
    s2_nxt.hue  = (h3 >= 10'd360) ? 9'(h3 - 10'd360) : h3[8:0];
    s2_nxt.cc   = cc[8:0];
    s2_nxt.rr   = rr[7:0];
    s2_nxt.code = s1.code;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

// File: src/cdgp_glyph.sv
module cdgp_glyph (
  input  logic           clk,
  input  logic           adv,
  input  cdgp_pkg::s2_t  s2,
  output cdgp_pkg::s3_t  s3_r
);

  cdgp_pkg::s3_t s3_nxt;

  always_comb begin
    logic signed [9:0]               ck;
    logic [3:0]                      w;
    logic                            row_ok;
    logic [cdgp_pkg::NUM_CHARS-1:0]  hit;
    row_ok = !s2.rr[7] && ($signed(s2.rr) < 8'(cdgp_pkg::GLYPH_ROWS));
    for (int k = 0; k < cdgp_pkg::NUM_CHARS; k++) begin
      ck = $signed({s2.cc[8], s2.cc}) - $signed({4'b0000, s2.start[k]});
      w  = cdgp_pkg::char_width(s2.code[k]);
      hit[k] = (w != 4'd0) && !ck[9] && (ck[8:0] < {5'b00000, w}) && row_ok &&
               cdgp_pkg::glyph_bit(s2.code[k], s2.rr[3:0], ck[2:0]);
    end
    s3_nxt.row = s2.row;
    s3_nxt.col = s2.col;
    s3_nxt.hue = s2.hue;
    s3_nxt.lit = |hit;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

// File: src/cdgp_glow.sv
module cdgp_glow (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cdgp_pkg::ctl_t                      ctl,
  input  logic [cdgp_pkg::ADDR_W-1:0]         rd_addr,
  input  cdgp_pkg::s3_t                       s3,
  input  logic [cdgp_pkg::LEVEL_W-1:0]        decay_factor,
  input  logic [cdgp_pkg::LEVEL_W-1:0]        bg_level,
  output cdgp_pkg::res_t                      res_r,
  output logic                                clr_busy
);

  typedef struct packed {
    logic [cdgp_pkg::ROW_W-1:0]     row;
    logic [cdgp_pkg::COL_W-1:0]     col;
    logic [cdgp_pkg::HUE_W-1:0]     hue;
    logic                           lit;
    logic                           ge;
    logic [cdgp_pkg::LEVEL_W-1:0]   target;
    logic [2*cdgp_pkg::LEVEL_W-1:0] prod;
  } s4_t;

  logic [cdgp_pkg::LEVEL_W-1:0] mem [cdgp_pkg::STORE_DEPTH];
  logic [cdgp_pkg::LEVEL_W-1:0] rdata_r;

  s4_t s4_r, s4_nxt;

  logic                         lw_vld_r;
  logic [cdgp_pkg::ADDR_W-1:0]  lw_addr_r;
  logic [cdgp_pkg::LEVEL_W-1:0] lw_data_r;

  logic                         clr_busy_r;
  logic [cdgp_pkg::ADDR_W-1:0]  clr_addr_r;

  logic [cdgp_pkg::ADDR_W-1:0]  s3_addr;
  logic [cdgp_pkg::ADDR_W-1:0]  s4_addr;
  logic [cdgp_pkg::LEVEL_W-1:0] old_lvl;
  logic [cdgp_pkg::LEVEL_W-1:0] new_lvl;
  logic                         wr_en;

  assign clr_busy = clr_busy_r;
  assign s3_addr  = cdgp_pkg::store_addr(s3.row, s3.col);
  assign s4_addr  = cdgp_pkg::store_addr(s4_r.row, s4_r.col);
  assign wr_en    = ctl.adv && ctl.s4_vld;

  // The read for stage three went out one transfer earlier, so the two newer
  // writes (stage four, and the one that landed on that same edge) are bypassed.
  always_comb begin
    if (ctl.s4_vld && s4_addr == s3_addr) begin
      old_lvl = new_lvl;
    end else if (lw_vld_r && lw_addr_r == s3_addr) begin
      old_lvl = lw_data_r;
    end else begin
      old_lvl = rdata_r;
    end
  end

  always_comb begin
    logic [cdgp_pkg::LEVEL_W-1:0] target;
    logic [cdgp_pkg::LEVEL_W-1:0] mag;
    target = s3.lit ? '0 : bg_level;
    s4_nxt.row    = s3.row;
    s4_nxt.col    = s3.col;
    s4_nxt.hue    = s3.hue;
    s4_nxt.lit    = s3.lit;
    s4_nxt.target = target;
    s4_nxt.ge     = (old_lvl >= target);
    mag           = s4_nxt.ge ? (old_lvl - target) : (target - old_lvl);
    s4_nxt.prod   = mag * decay_factor;
  end

  always_comb begin
    logic [2*cdgp_pkg::LEVEL_W-1:0] rnd;
    logic [cdgp_pkg::LEVEL_W-1:0]   q;
    // Round to nearest; the sum cannot carry out of 32 bits.
    rnd = s4_r.prod + (2*cdgp_pkg::LEVEL_W)'(1 << (cdgp_pkg::LEVEL_W - 1));
    q   = rnd[2*cdgp_pkg::LEVEL_W-1:cdgp_pkg::LEVEL_W];
    new_lvl = s4_r.ge ? (s4_r.target + q) : (s4_r.target - q);
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[s4_addr] <= new_lvl;
    end
    if (ctl.adv) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s4_r         <= s4_nxt;
      res_r.row    <= s4_r.row;
      res_r.col    <= s4_r.col;
      res_r.hue    <= s4_r.hue;
      res_r.level  <= new_lvl;
      res_r.lit    <= s4_r.lit;
    end
    if (wr_en) begin
      lw_addr_r <= s4_addr;
      lw_data_r <= new_lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_vld_r   <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (wr_en) begin
        lw_vld_r <= 1'b1;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == cdgp_pkg::ADDR_W'(cdgp_pkg::STORE_DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

// File: src/clock_digit_glow_pixel.sv
// Glow renderer for an HH:MM:SS matrix clock. Each in_tdata transfer names one
// pixel and the six time digits; one result comes out per pixel, in order. The
// pixel passes the input, layout, glyph test, decay multiply and output registers
// before out_tvalid rises, and the result transfers while out_tready is high. A
// new pixel is taken every clock while out_tready is high, including the same
// pixel twice in a row: the read-modify-write of the 8192-entry level store
// bypasses the two writes still in flight. After reset the store is cleared one
// entry per clock, so in_tready stays low until the clear is done. Configuration
// writes are taken on any cycle (cfg_ready is always high) and must only be
// issued while no pixel is in flight.
module clock_digit_glow_pixel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pixel_row[5:0], pixel_col[12:6], hour_tens[14:13], hour_units[18:15],
  // minute_tens[21:19], minute_units[25:22], second_tens[28:26],
  // second_units[32:29], zero fill up to bit 39
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_row[5:0], out_col[12:6], hue_deg[21:13], lightness[37:22], zero fill
  output logic [39:0] out_tdata,
  // in_glyph[0]
  output logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [2:0] REG_ACTIVE_ROWS  = 3'd0;
  localparam logic [2:0] REG_ACTIVE_COLS  = 3'd1;
  localparam logic [2:0] REG_DECAY_FACTOR = 3'd2;
  localparam logic [2:0] REG_BG_LEVEL     = 3'd3;

  logic [6:0]  active_rows_r;
  logic [7:0]  active_cols_r;
  logic [15:0] decay_factor_r;
  logic [15:0] bg_level_r;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  logic adv;
  logic accept;
  logic clr_busy;

  cdgp_pkg::s1_t  s1_r;
  cdgp_pkg::s1_t  s1_nxt;
  cdgp_pkg::s2_t  s2;
  cdgp_pkg::s3_t  s3;
  cdgp_pkg::res_t res;
  cdgp_pkg::ctl_t ctl;

  // The whole pipeline moves together whenever the output register can take.
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv && !clr_busy;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign ctl.adv    = adv;
  assign ctl.s4_vld = s4_vld_r;

  always_comb begin
    s1_nxt.row     = in_tdata[5:0];
    s1_nxt.col     = in_tdata[12:6];
    s1_nxt.code[0] = {2'b00, in_tdata[14:13]};
    s1_nxt.code[1] = in_tdata[18:15];
    s1_nxt.code[2] = cdgp_pkg::COLON_CODE;
    s1_nxt.code[3] = {1'b0, in_tdata[21:19]};
    s1_nxt.code[4] = in_tdata[25:22];
    s1_nxt.code[5] = cdgp_pkg::COLON_CODE;
    s1_nxt.code[6] = {1'b0, in_tdata[28:26]};
    s1_nxt.code[7] = in_tdata[32:29];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_rows_r  <= 7'd59;
      active_cols_r  <= 8'd79;
      decay_factor_r <= 16'd62180;
      bg_level_r     <= 16'd39322;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACTIVE_ROWS:  active_rows_r  <= cfg_data[6:0];
        REG_ACTIVE_COLS:  active_cols_r  <= cfg_data[7:0];
        REG_DECAY_FACTOR: decay_factor_r <= cfg_data;
        REG_BG_LEVEL:     bg_level_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= accept;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  cdgp_layout u_layout (
    .clk         (clk),
    .adv         (adv),
    .s1          (s1_r),
    .active_rows (active_rows_r),
    .active_cols (active_cols_r),
    .s2_r        (s2)
  );

  cdgp_glyph u_glyph (
    .clk  (clk),
    .adv  (adv),
    .s2   (s2),
    .s3_r (s3)
  );

  cdgp_glow u_glow (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .rd_addr      (cdgp_pkg::store_addr(s2.row, s2.col)),
    .s3           (s3),
    .decay_factor (decay_factor_r),
    .bg_level     (bg_level_r),
    .res_r        (res),
    .clr_busy     (clr_busy)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, res.level, res.hue, res.col, res.row};
  assign out_tuser  = res.lit;

endmodule

// File: src/cdgp_checker.sv
`include "clock_digit_glow_pixel_macros.svh"

module cdgp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [0:0]  out_tuser
);

  logic [7:0] pix_sum;
  logic [9:0] hue_x3;
  logic [8:0] hue_exp;

  assign pix_sum = {2'b00, out_tdata[5:0]} + {1'b0, out_tdata[12:6]};
  assign hue_x3  = {1'b0, pix_sum, 1'b0} + {2'b00, pix_sum};
  assign hue_exp = (hue_x3 >= 10'd360) ? 9'(hue_x3 - 10'd360) : hue_x3[8:0];

  // A stalled result keeps its payload.
  `CDGP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // The hue travels with its own pixel coordinates.
  `CDGP_ASSERT_IMPL(a_hue_match, out_tvalid, out_tdata[21:13] == hue_exp, "hue does not match pixel")

  // A full, stalled output register freezes the whole pipeline.
  `CDGP_ASSERT_IMPL(a_backpressure, out_tvalid && !out_tready, !in_tready, "input taken while output stalled")

  // Right after reset the level store is being cleared.
  `CDGP_ASSERT_IMPL(a_clear_gate, $past(!rst_n), !in_tready, "input taken during store clear")

endmodule

bind clock_digit_glow_pixel cdgp_checker u_cdgp_checker (.*);

// File: tb/clock_digit_glow_pixel_tb.sv
package glow_tb_pkg;

  typedef enum logic [2:0] {
    REG_ACTIVE_ROWS = 3'd0,
    REG_ACTIVE_COLS = 3'd1,
    REG_DECAY       = 3'd2,
    REG_BG_LEVEL    = 3'd3
  } cfg_reg_e;

  localparam logic [3:0] COLON_GLYPH  = 4'd10;
  localparam logic [3:0] NARROW_DIGIT = 4'd1;
  localparam logic [3:0] LAST_DIGIT   = 4'd9;
  localparam int GLYPH_H   = 10;
  localparam int ROW_LIFT  = 14;
  localparam int MEM_DEPTH = 8192;

  // Row patterns of the ten digits and the colon, bit c is column offset c.
  localparam logic [7:0] FONT [0:10][0:9] = '{
    '{8'h3C, 8'h7E, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h7E, 8'h3C},
    '{8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06},
    '{8'h3E, 8'h7E, 8'h60, 8'h60, 8'h7C, 8'h3E, 8'h06, 8'h06, 8'h7E, 8'h7E},
    '{8'h3E, 8'h7E, 8'h60, 8'h60, 8'h38, 8'h38, 8'h60, 8'h60, 8'h7E, 8'h3E},
    '{8'h66, 8'h66, 8'h66, 8'h66, 8'h7E, 8'h7C, 8'h60, 8'h60, 8'h60, 8'h60},
    '{8'h7E, 8'h7E, 8'h06, 8'h06, 8'h3E, 8'h7E, 8'h60, 8'h60, 8'h7E, 8'h3E},
    '{8'h7C, 8'h7E, 8'h06, 8'h06, 8'h3E, 8'h7E, 8'h66, 8'h66, 8'h7E, 8'h3C},
    '{8'h7E, 8'h7E, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60},
    '{8'h3C, 8'h7E, 8'h66, 8'h66, 8'h3C, 8'h3C, 8'h66, 8'h66, 8'h7E, 8'h3C},
    '{8'h3C, 8'h7E, 8'h66, 8'h66, 8'h7E, 8'h7C, 8'h60, 8'h60, 8'h60, 8'h60},
    '{8'h00, 8'h00, 8'h06, 8'h06, 8'h00, 8'h00, 8'h06, 8'h06, 8'h00, 8'h00}
  };

  typedef struct {
    logic [5:0]  row;
    logic [6:0]  col;
    logic [8:0]  hue;
    logic [15:0] level;
    logic        lit;
  } glow_result_t;

  class glow_tracker;
    logic [6:0]   rows_cfg;
    logic [7:0]   cols_cfg;
    logic [15:0]  decay_cfg;
    logic [15:0]  bg_cfg;
    logic [15:0]  glow_mem [MEM_DEPTH];
    glow_result_t due_pixels [$];
    int           bad_pixels;

    function new();
      rows_cfg   = 7'd59;
      cols_cfg   = 8'd79;
      decay_cfg  = 16'd62180;
      bg_cfg     = 16'd39322;
      bad_pixels = 0;
      foreach (glow_mem[i]) glow_mem[i] = 16'h0000;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [15:0] value);
      case (idx)
        REG_ACTIVE_ROWS: rows_cfg = value[6:0];
        REG_ACTIVE_COLS: cols_cfg = value[7:0];
        REG_DECAY:       decay_cfg = value;
        REG_BG_LEVEL:    bg_cfg = value;
        default: ;
      endcase
    endfunction

    function int glyph_width(logic [3:0] code);
      if (code == COLON_GLYPH || code == NARROW_DIGIT) return 4;
      if (code <= LAST_DIGIT) return 8;
      return 0;
    endfunction

    // Works out the glyph test and the decayed level for one accepted pixel.
    function void take_pixel(logic [39:0] word);
      logic [3:0]   codes [8];
      logic [5:0]   row;
      logic [6:0]   col;
      logic [15:0]  target;
      logic [15:0]  old;
      logic [31:0]  delta;
      logic [31:0]  q;
      glow_result_t px;
      int           span, d, x, r, c, w;
      row      = word[5:0];
      col      = word[12:6];
      codes[0] = {2'b00, word[14:13]};
      codes[1] = word[18:15];
      codes[2] = COLON_GLYPH;
      codes[3] = {1'b0, word[21:19]};
      codes[4] = word[25:22];
      codes[5] = COLON_GLYPH;
      codes[6] = {1'b0, word[28:26]};
      codes[7] = word[32:29];
      span = 0;
      for (int k = 0; k < 8; k++) span += glyph_width(codes[k]);
      d = int'(cols_cfg) - span;
      // Floor of d/2, also for a string wider than the matrix.
      x = (d >= 0) ? d / 2 : -((1 - d) / 2);
      r = int'(row) - (int'(rows_cfg) - ROW_LIFT);
      px.lit = 1'b0;
      for (int k = 0; k < 8; k++) begin
        w = glyph_width(codes[k]);
        c = int'(col) - x;
        if (w > 0 && c >= 0 && c < w && r >= 0 && r < GLYPH_H) begin
          if (FONT[codes[k]][r][c]) px.lit = 1'b1;
        end
        x += w;
      end
      target = px.lit ? 16'h0000 : bg_cfg;
      old = glow_mem[{row, col}];
      if (old >= target) begin
        delta = 32'(old - target);
        q = (delta * 32'(decay_cfg) + 32'd32768) >> 16;
        px.level = target + q[15:0];
      end else begin
        delta = 32'(target - old);
        q = (delta * 32'(decay_cfg) + 32'd32768) >> 16;
        px.level = target - q[15:0];
      end
      glow_mem[{row, col}] = px.level;
      px.row = row;
      px.col = col;
      px.hue = 9'((3 * (int'(row) + int'(col))) % 360);
      due_pixels.push_back(px);
    endfunction

    function void check_result(logic [39:0] word, logic glyph_flag);
      glow_result_t want;
      if (due_pixels.size() == 0) begin
        bad_pixels++;
        if (bad_pixels <= 10)
          $display("%0t: result (%0d,%0d) level %0d arrived with no pixel pending",
                   $realtime, word[5:0], word[12:6], word[37:22]);
        return;
      end
      want = due_pixels.pop_front();
      if (word[5:0] !== want.row || word[12:6] !== want.col || word[21:13] !== want.hue ||
          word[37:22] !== want.level || glyph_flag !== want.lit) begin
        bad_pixels++;
        if (bad_pixels <= 10) begin
          $display("%0t: expected (%0d,%0d) hue %0d level %0d glyph %0d",
                   $realtime, want.row, want.col, want.hue, want.level, want.lit);
          $display("      got (%0d,%0d) hue %0d level %0d glyph %0d",
                   word[5:0], word[12:6], word[21:13], word[37:22], glyph_flag);
        end
      end
    endfunction
  endclass

endpackage

module clock_digit_glow_pixel_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import glow_tb_pkg::*;

  // Covers the store clearing pass after reset plus the longest receiver hold.
  localparam int STALL_LIMIT = 50000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  glow_tracker glow = new();

  int          results_done   = 0;
  int          quiet_cycles   = 0;
  int          calm_left      = 0;
  int          stall_left     = 0;
  int          steady_left    = 0;
  bit          long_hold_done = 1'b0;
  logic [19:0] shown_time;
  logic [12:0] recent_px [4] = '{13'd0, 13'd0, 13'd0, 13'd0};
  logic [15:0] phase_cfg [5][4] = '{
    '{16'd15,  16'd57,  16'd0,     16'd65535},
    '{16'd64,  16'd128, 16'd65535, 16'd0},
    '{16'd0,   16'd0,   16'd32768, 16'd1234},
    '{16'd127, 16'd255, 16'd1,     16'd65534},
    '{16'd40,  16'd100, 16'd50000, 16'd20000}
  };

  clock_digit_glow_pixel DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [19:0] time_bits(int ht, int hu, int mt, int mu, int st, int su);
    return {4'(su), 3'(st), 4'(mu), 3'(mt), 4'(hu), 2'(ht)};
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic push_pixel(logic [5:0] row, logic [6:0] col, logic [19:0] digits,
                            int idle_after);
    logic [39:0] word;
    word = {7'b0, digits, col, row};
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    glow.take_pixel(word);
    recent_px[3] = recent_px[2];
    recent_px[2] = recent_px[1];
    recent_px[1] = recent_px[0];
    recent_px[0] = {row, col};
    if (idle_after > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (idle_after - 1) @(negedge clk);
    end
  endtask

  task automatic drain_pixels();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (glow.due_pixels.size() > 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    glow.set_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Frames of pixels: most hit the glyph band, many revisit recent pixels so
  // the levels build up over several updates, the rest land anywhere.
  task automatic run_phase(int count, bit pause_mid);
    logic [5:0] row;
    logic [6:0] col;
    int         sel;
    int         gap;
    for (int i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) drain_pixels();
      if ($urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 6) != 0)
          shown_time = time_bits($urandom_range(0, 2), $urandom_range(0, 9),
                                 $urandom_range(0, 5), $urandom_range(0, 9),
                                 $urandom_range(0, 5), $urandom_range(0, 9));
        else
          shown_time = 20'($urandom);
      end
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        {row, col} = recent_px[$urandom_range(0, 3)];
      end else if (sel < 80) begin
        row = 6'(int'(glow.rows_cfg) - ROW_LIFT - 1 + $urandom_range(0, 11));
        col = 7'((int'(glow.cols_cfg) - 56) / 2 - 1 + $urandom_range(0, 57));
      end else begin
        row = 6'($urandom);
        col = 7'($urandom);
      end
      if (calm_left > 0) begin
        calm_left--;
        gap = 0;
      end else begin
        if ($urandom_range(0, 39) == 0) calm_left = 50;
        gap = pick_gap();
      end
      push_pixel(row, col, shown_time, gap);
    end
  endtask

  // Receiver side: random stalls, steady stretches and one long hold-off.
  initial begin
    int p;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_done >= 430) begin
        long_hold_done = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (steady_left > 0) begin
        out_tready <= 1'b1;
        steady_left--;
      end else begin
        p = $urandom_range(0, 99);
        if (p < 4) steady_left = 80;
        else if (p < 30) stall_left = pick_gap();
        if (stall_left > 0) begin
          out_tready <= 1'b0;
          stall_left--;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      glow.check_result(out_tdata, out_tuser[0]);
      results_done++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [19:0] t_mixed;
    logic [19:0] t_zero;
    logic [19:0] t_ones;
    logic [19:0] t_odd;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ACTIVE_ROWS;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset layout: glyph band on rows 45..54. For 12:34:56 the string starts
    // at column 13, so the narrow one lights columns 14 and 15.
    t_mixed = time_bits(1, 2, 3, 4, 5, 6);
    t_zero  = time_bits(0, 0, 0, 0, 0, 0);
    t_ones  = time_bits(1, 1, 1, 1, 1, 1);
    t_odd   = time_bits(3, 15, 7, 15, 7, 15);
    push_pixel(6'd47, 7'd14, t_mixed, 0);
    push_pixel(6'd47, 7'd14, t_mixed, 0);
    push_pixel(6'd47, 7'd14, t_mixed, 0);
    push_pixel(6'd47, 7'd13, t_mixed, 1);
    push_pixel(6'd47, 7'd26, t_mixed, 0);
    push_pixel(6'd46, 7'd26, t_mixed, 0);
    push_pixel(6'd45, 7'd15, t_mixed, 0);
    push_pixel(6'd54, 7'd15, t_mixed, 0);
    push_pixel(6'd55, 7'd15, t_mixed, 0);
    push_pixel(6'd44, 7'd15, t_mixed, 2);
    push_pixel(6'd47, 7'd14, t_mixed, 0);
    push_pixel(6'd0, 7'd0, t_zero, 0);
    push_pixel(6'd63, 7'd127, t_zero, 0);
    push_pixel(6'd50, 7'd30, time_bits(2, 3, 5, 9, 5, 9), 0);
    push_pixel(6'd50, 7'd24, t_ones, 0);
    push_pixel(6'd50, 7'd25, t_ones, 0);
    push_pixel(6'd50, 7'd30, t_odd, 0);
    push_pixel(6'd63, 7'd127, t_odd, 0);
    push_pixel(6'd60, 7'd100, t_mixed, 0);
    push_pixel(6'd50, 7'd24, t_ones, 3);

    shown_time = t_mixed;
    run_phase(185, 1'b1);

    phase_cfg[4][0] = 16'($urandom_range(15, 64));
    phase_cfg[4][1] = 16'($urandom_range(57, 128));
    phase_cfg[4][2] = 16'($urandom);
    phase_cfg[4][3] = 16'($urandom);
    for (int k = 0; k < 5; k++) begin
      drain_pixels();
      for (int i = 0; i < 4; i++) write_reg(cfg_reg_e'(i), phase_cfg[k][i]);
      run_phase(185, 1'b0);
    end

    drain_pixels();
    repeat (10) @(posedge clk);
    if (glow.bad_pixels == 0 && glow.due_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/cdgp_pkg.sv
src/cdgp_layout.sv
src/cdgp_glyph.sv
src/cdgp_glow.sv
src/clock_digit_glow_pixel.sv
src/cdgp_checker.sv
tb/clock_digit_glow_pixel_tb.sv
